[rtl/bvrm_pkg.sv]
// Shared types, constants and address helpers for the banked VRAM remapper.
// No dependencies; imported by every other file of the block.
package bvrm_pkg;

  // Store geometry (eight banks of 2 KiB)
  localparam int BANK_COUNT  = 8;
  localparam int BANK_BYTES  = 2048;
  localparam int STORE_DEPTH = BANK_COUNT * BANK_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int BANK_W      = $clog2(BANK_COUNT);
  localparam int OFFS_W      = $clog2(BANK_BYTES);
  localparam int TILE_W      = 10;
  localparam int DATA_W      = 8;
  localparam int TARGET_W    = 15;
  localparam int QUEUE_DEPTH = 2;

  // Input op codes
  localparam logic [1:0] OP_BANK_WR = 2'd0;
  localparam logic [1:0] OP_VRAM_WR = 2'd1;
  localparam logic [1:0] OP_VRAM_RD = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_TILE  = 2'd0;
  localparam logic [1:0] KIND_BANK  = 2'd1;
  localparam logic [1:0] KIND_PLANE = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Classified command kinds carried through the queue
  typedef enum logic [1:0] {
    CMD_TILE  = 2'd0,
    CMD_BANK  = 2'd1,
    CMD_PLANE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [ADDR_W-1:0]   addr;
    logic [DATA_W-1:0]   data;
  } bvrm_cmd_t;

  // Plane store base for the 1 KiB region given by address bits 12:10.
  // hi_sel picks the high-nibble plane. Regions without planes return 0.
  function automatic logic [TARGET_W-1:0] plane_base(input logic [2:0] region,
                                                     input logic hi_sel);
    logic [TARGET_W-1:0] base;
    base = '0;
    unique case (region)
      3'd1:    base = hi_sel ? 15'h2000 : 15'h0000;
      3'd2:    base = hi_sel ? 15'h4400 : 15'h4000;
      3'd3:    base = hi_sel ? 15'h2400 : 15'h0400;
      3'd5:    base = hi_sel ? 15'h2800 : 15'h0800;
      3'd6:    base = hi_sel ? 15'h4c00 : 15'h4800;
      3'd7:    base = hi_sel ? 15'h2c00 : 15'h0c00;
      default: base = '0;
    endcase
    return base;
  endfunction

endpackage

[rtl/bvrm_front.sv]
// Front end: takes bus transfers, holds the bank register, classifies VRAM accesses.
// Depends on bvrm_pkg; feeds bvrm_queue.
module bvrm_front
  import bvrm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [ADDR_W-1:0] bus_offset,
  input  logic [DATA_W-1:0] bus_data,
  input  logic              q_full,
  output logic              q_push,
  output bvrm_cmd_t         q_cmd
);

  logic [DATA_W-1:0] bank_reg_r;
  logic [DATA_W-1:0] bank_reg_nxt;
  logic [BANK_W-1:0] bank;
  logic [OFFS_W-1:0] low;
  logic [ADDR_W-1:0] bank_addr;
  logic              accept;
  logic              is_tile;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Bank register: bits 3:1 select the bank
  always_comb begin
    bank_reg_nxt = bank_reg_r;
    if (accept && op == OP_BANK_WR) begin
      bank_reg_nxt = bus_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_reg_r <= '0;
    end else begin
      bank_reg_r <= bank_reg_nxt;
    end
  end

  // Address remap and classification
  assign bank      = bank_reg_r[BANK_W:1];
  assign low       = bus_offset[OFFS_W-1:0];
  assign bank_addr = {bank, low};
  assign is_tile   = !bank[0] && !low[TILE_W];

  always_comb begin
    q_push       = 1'b0;
    q_cmd.kind   = CMD_READ;
    q_cmd.addr   = bus_offset;
    q_cmd.data   = bus_data;
    if (accept && op == OP_VRAM_RD) begin
      q_push = 1'b1;
    end else if (accept && op == OP_VRAM_WR) begin
      q_push = 1'b1;
      if (is_tile) begin
        q_cmd.kind = CMD_TILE;
        q_cmd.addr = {{(ADDR_W-TILE_W){1'b0}}, low[TILE_W-1:0]};
      end else begin
        // planes exist unless region bits 11:10 are both zero
        q_cmd.kind = (bank_addr[11:10] != 2'b00) ? CMD_PLANE : CMD_BANK;
        q_cmd.addr = bank_addr;
      end
    end
  end

endmodule

[rtl/bvrm_queue.sv]
// Short command queue between the front end and the back end.
// Depends on bvrm_pkg for the command type.
module bvrm_queue
  import bvrm_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bvrm_cmd_t push_cmd,
  input  logic      pop,
  output bvrm_cmd_t head,
  output logic      empty,
  output logic      full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bvrm_cmd_t          slots_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/bvrm_back.sv]
// Back end: owns the 16 KiB video store, performs each command, sequences results.
// Depends on bvrm_pkg; drains bvrm_queue and drives the result register.
module bvrm_back
  import bvrm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  bvrm_cmd_t           q_head,
  input  logic                q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [TARGET_W-1:0] out_target,
  output logic [DATA_W-1:0]   out_value,
  output logic                out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [DATA_W-1:0]   mem [STORE_DEPTH];
  logic [DATA_W-1:0]   rd_data_r;
  logic                state_r, state_nxt;
  logic [1:0]          step_r, step_nxt;
  bvrm_cmd_t           cur_r;
  logic                out_valid_r;
  logic [1:0]          out_kind_r;
  logic [TARGET_W-1:0] out_target_r;
  logic [DATA_W-1:0]   out_value_r;
  logic                out_last_r;
  logic                slot_free;
  logic                emit;
  logic                last_step;
  logic [1:0]          res_kind;
  logic [TARGET_W-1:0] res_target;
  logic [DATA_W-1:0]   res_value;
  logic [TARGET_W-1:0] plane_off;
  logic [TARGET_W-1:0] cur_addr_ext;

  assign slot_free = !out_valid_r || out_ready;
  assign emit      = (state_r == ST_EMIT) && slot_free;
  assign last_step = (cur_r.kind != CMD_PLANE) || (step_r == 2'd2);
  assign q_pop     = !q_empty && ((state_r == ST_IDLE) || (emit && last_step));

  // Store access happens in the cycle a command leaves the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.kind == CMD_READ) begin
        rd_data_r <= mem[q_head.addr];
      end else begin
        mem[q_head.addr] <= q_head.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // Result sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    if (q_pop) begin
      state_nxt = ST_EMIT;
      step_nxt  = 2'd0;
    end else if (emit) begin
      if (last_step) begin
        state_nxt = ST_IDLE;
      end else begin
        step_nxt = step_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Plane address: region offset, base, plus 0x1000 for banks 4 to 7
  assign cur_addr_ext = {{(TARGET_W-ADDR_W){1'b0}}, cur_r.addr};
  assign plane_off    = {{(TARGET_W-TILE_W){1'b0}}, cur_r.addr[TILE_W-1:0]}
                      + {2'b00, cur_r.addr[ADDR_W-1], 12'h000};

  always_comb begin
    res_kind   = KIND_READ;
    res_target = cur_addr_ext;
    res_value  = cur_r.data;
    unique case (cur_r.kind)
      CMD_TILE: res_kind = KIND_TILE;
      CMD_BANK: res_kind = KIND_BANK;
      CMD_READ: res_value = rd_data_r;
      CMD_PLANE: begin
        if (step_r == 2'd0) begin
          res_kind = KIND_BANK;
        end else begin
          res_kind   = KIND_PLANE;
          res_target = plane_off + plane_base(cur_r.addr[12:10], step_r[1]);
          res_value  = step_r[1] ? {4'h0, ~cur_r.data[7:4]}
                                 : {4'h0, ~cur_r.data[3:0]};
        end
      end
      default: res_kind = KIND_READ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r   <= res_kind;
      out_target_r <= res_target;
      out_value_r  <= res_value;
      out_last_r   <= last_step;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_target = out_target_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;

endmodule

[rtl/banked_vram_bitplane_remapper.sv]
// Top level of the banked VRAM bus front end with bit-plane remapping.
// Depends on bvrm_pkg, bvrm_front, bvrm_queue and bvrm_back.

// A bank register write is taken into the bank register and yields no result.
// A VRAM read, tile write or plain banked write goes into a short command queue
// and leaves it while the single-port video store is accessed; its one result
// is then registered at the output. Such accesses sustain one per cycle while
// the output is ready. A banked write into a region with graphics planes yields
// three results (stored byte, low-nibble plane, high-nibble plane) and occupies
// the result sequencer until all three are emitted. The result sequencer, one
// result per cycle while the output is ready, sets the rate. The store has no
// reset; reading an address never written returns an undefined byte.
module banked_vram_bitplane_remapper
  import bvrm_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [13:0] bus_offset, [21:14] bus_data, [23:22] zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [14:0] target_address, [22:15] value, [23] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast
);

  bvrm_cmd_t           push_cmd;
  bvrm_cmd_t           head;
  logic                push, pop, q_empty, q_full;
  logic [TARGET_W-1:0] out_target;
  logic [DATA_W-1:0]   out_value;

  bvrm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (in_tuser),
    .bus_offset (in_tdata[ADDR_W-1:0]),
    .bus_data   (in_tdata[ADDR_W+DATA_W-1:ADDR_W]),
    .q_full     (q_full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  bvrm_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  bvrm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (head),
    .q_empty    (q_empty),
    .q_pop      (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_target (out_target),
    .out_value  (out_value),
    .out_last   (out_tlast)
  );

  assign out_tdata = {1'b0, out_value, out_target};

  // Queue is never pushed while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue pushed while full");

  // Reads and tile writes give exactly one result
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == KIND_READ || out_tuser == KIND_TILE) |-> out_tlast)
    else $error("single-result transfer without last");

  // Plane results carry an inverted nibble only
  a_plane_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PLANE |-> out_tdata[22:19] == 4'h0)
    else $error("plane value wider than a nibble");

  // A non-final stored byte is followed by a plane result
  a_plane_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_BANK && !out_tlast
      |=> !out_tvalid || out_tuser == KIND_PLANE)
    else $error("stored byte without its plane results");

endmodule
